// ===== hw/rtl/integer_set_successor_macros.svh =====
// Assertion macros shared by the integer set successor RTL.
`ifndef INTEGER_SET_SUCCESSOR_MACROS_SVH
`define INTEGER_SET_SUCCESSOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define ISS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define ISS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/iss_pkg.sv =====
// Package with types and constants of the integer set successor block.
`default_nettype none

package iss_pkg;

	localparam int KEY_BITS_DEF = 16;
	localparam int OPCODE_W     = 2;
	localparam int KEY_W        = 16;
	localparam int NEXT_W       = 17;
	localparam int WORD_W       = 64;
	localparam int POS_W        = 6;
	localparam int S_DATA_W     = 24;
	localparam int M_DATA_W     = 24;

	typedef enum logic [OPCODE_W-1:0] {
		OP_INSERT = 2'd0,
		OP_TEST   = 2'd1,
		OP_SEARCH = 2'd2,
		OP_NONE   = 2'd3
	} opcode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_WORD,
		ST_L1,
		ST_L2,
		ST_RD,
		ST_OUT
	} state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/iss_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module iss_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/iss_ffs.sv =====
// Shared find-first-set unit: lowest set bit at or above a start position.
`default_nettype none

module iss_ffs (
	input  wire logic [iss_pkg::WORD_W-1:0] vec,
	input  wire logic [iss_pkg::POS_W-1:0]  pos,
	output logic                            hit,
	output logic      [iss_pkg::POS_W-1:0]  idx
);

	logic [iss_pkg::WORD_W-1:0] masked;
	logic [iss_pkg::WORD_W-1:0] lowest;

	always_comb begin
		masked = vec & ({iss_pkg::WORD_W{1'b1}} << pos);
		lowest = masked & (~masked + iss_pkg::WORD_W'(1));
		hit    = |masked;
		idx    = '0;
		for (int b = 0; b < iss_pkg::POS_W; b++) begin
			for (int j = 0; j < iss_pkg::WORD_W; j++) begin
				if (((j >> b) & 1) == 1) begin
					idx[b] = idx[b] | lowest[j];
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/integer_set_successor.sv =====
// Integer set with insert, membership test and successor search (top level).
// One item at a time, one find-first unit; no new beat until the result is taken.
// A search walks the bitmap word, the level-1 summary, the level-2 summary and back.
// Reset clears the sequencer and both summary levels; the bitmap RAM is not swept,
// its words read as zero until the level-1 bit of that word is set.
`default_nettype none
`include "integer_set_successor_macros.svh"

module integer_set_successor #(
	parameter int KEY_BITS = iss_pkg::KEY_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         s_tvalid,
	output logic                              s_tready,
	// opcode [1:0], key [17:2], zero [23:18]
	input  wire logic [iss_pkg::S_DATA_W-1:0] s_tdata,
	output logic                              m_tvalid,
	input  wire logic                         m_tready,
	// found [0], next_key [17:1], zero [23:18]
	output logic      [iss_pkg::M_DATA_W-1:0] m_tdata
);

	localparam int KB      = (KEY_BITS > iss_pkg::KEY_W) ? iss_pkg::KEY_W : KEY_BITS;
	localparam int W_BITS  = KB - iss_pkg::POS_W;
	localparam int WORDS   = 1 << W_BITS;
	localparam int I_BITS  = (W_BITS > iss_pkg::POS_W) ? W_BITS - iss_pkg::POS_W : 1;
	localparam int WX_BITS = I_BITS + iss_pkg::POS_W;
	localparam int L1_ROWS = 1 << I_BITS;
	localparam int L1_N    = (WORDS + iss_pkg::WORD_W - 1) / iss_pkg::WORD_W;
	localparam logic [iss_pkg::NEXT_W-1:0] NONE_KEY =
		iss_pkg::NEXT_W'((KEY_BITS > iss_pkg::KEY_W) ? 0 : (1 << KEY_BITS));

	iss_pkg::state_t  state_q, state_d;
	iss_pkg::opcode_t op_q;
	iss_pkg::opcode_t in_op;

	logic [iss_pkg::KEY_W-1:0]       in_key;
	logic                            in_range;
	logic                            range_q;
	logic [W_BITS-1:0]               w_q;
	logic [I_BITS-1:0]               i_q;
	logic [iss_pkg::POS_W-1:0]       pos_q;
	logic                            found_q;
	logic [iss_pkg::NEXT_W-1:0]      next_q;
	logic [L1_ROWS*iss_pkg::WORD_W-1:0] l1_q;
	logic [L1_ROWS-1:0]              group_q;

	logic                            accept;
	logic [WX_BITS-1:0]              wx_cur;
	logic [W_BITS:0]                 w1;
	logic [WX_BITS-1:0]              wx_next;
	logic [I_BITS:0]                 i1;
	logic                            i_end;
	logic                            word_valid;
	logic [iss_pkg::WORD_W-1:0]      base_word;
	logic [iss_pkg::WORD_W-1:0]      l1_row;

	logic                            ram_we;
	logic [iss_pkg::WORD_W-1:0]      ram_wdata;
	logic                            ram_re;
	logic [W_BITS-1:0]               ram_raddr;
	logic [iss_pkg::WORD_W-1:0]      ram_rdata;

	logic [iss_pkg::WORD_W-1:0]      ffs_vec;
	logic [iss_pkg::POS_W-1:0]       ffs_pos;
	logic                            ffs_hit;
	logic [iss_pkg::POS_W-1:0]       ffs_idx;

	assign in_op    = iss_pkg::opcode_t'(s_tdata[iss_pkg::OPCODE_W-1:0]);
	assign in_key   = s_tdata[iss_pkg::OPCODE_W +: iss_pkg::KEY_W];
	assign in_range = (iss_pkg::KEY_W'(in_key >> KB) == '0);
	assign accept   = s_tvalid && s_tready;

	assign wx_cur     = WX_BITS'(w_q);
	assign w1         = {1'b0, w_q} + (W_BITS+1)'(1);
	assign wx_next    = WX_BITS'(w1[W_BITS-1:0]);
	assign i1         = {1'b0, i_q} + (I_BITS+1)'(1);
	assign i_end      = (i1 >= (I_BITS+1)'(L1_N));
	assign word_valid = l1_q[wx_cur];
	assign base_word  = word_valid ? ram_rdata : '0;
	assign l1_row     = l1_q[{i_q, {iss_pkg::POS_W{1'b0}}} +: iss_pkg::WORD_W];
	assign ram_wdata  = base_word | (iss_pkg::WORD_W'(1) << pos_q);

	iss_ram #(
		.WIDTH (iss_pkg::WORD_W),
		.DEPTH (WORDS)
	) u_words (
		.clk   (clk),
		.we    (ram_we),
		.waddr (w_q),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	iss_ffs u_ffs (
		.vec (ffs_vec),
		.pos (ffs_pos),
		.hit (ffs_hit),
		.idx (ffs_idx)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			iss_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = iss_pkg::ST_WORD;
				end
			end
			iss_pkg::ST_WORD: begin
				priority if (op_q != iss_pkg::OP_SEARCH || !range_q || ffs_hit) begin
					state_d = iss_pkg::ST_OUT;
				end else if (w1[W_BITS]) begin
					state_d = iss_pkg::ST_OUT;
				end else begin
					state_d = iss_pkg::ST_L1;
				end
			end
			iss_pkg::ST_L1: begin
				priority if (ffs_hit) begin
					state_d = iss_pkg::ST_RD;
				end else if (i_end) begin
					state_d = iss_pkg::ST_OUT;
				end else begin
					state_d = iss_pkg::ST_L2;
				end
			end
			iss_pkg::ST_L2: begin
				state_d = ffs_hit ? iss_pkg::ST_L1 : iss_pkg::ST_OUT;
			end
			iss_pkg::ST_RD: begin
				state_d = iss_pkg::ST_WORD;
			end
			iss_pkg::ST_OUT: begin
				if (m_tready) begin
					state_d = iss_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = iss_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = 1'b0;
		m_tvalid  = 1'b0;
		ram_re    = 1'b0;
		ram_we    = 1'b0;
		ram_raddr = w_q;
		ffs_vec   = base_word;
		ffs_pos   = pos_q;
		unique case (state_q)
			iss_pkg::ST_IDLE: begin
				s_tready  = 1'b1;
				ram_re    = s_tvalid;
				ram_raddr = W_BITS'(in_key >> iss_pkg::POS_W);
			end
			iss_pkg::ST_WORD: begin
				ram_we = (op_q == iss_pkg::OP_INSERT) && range_q;
			end
			iss_pkg::ST_L1: begin
				ffs_vec = l1_row;
			end
			iss_pkg::ST_L2: begin
				ffs_vec = iss_pkg::WORD_W'(group_q);
			end
			iss_pkg::ST_RD: begin
				ram_re = 1'b1;
			end
			iss_pkg::ST_OUT: begin
				m_tvalid = 1'b1;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= iss_pkg::ST_IDLE;
			l1_q    <= '0;
			group_q <= '0;
		end else begin
			state_q <= state_d;
			if (ram_we) begin
				l1_q[wx_cur]                            <= 1'b1;
				group_q[wx_cur[WX_BITS-1:iss_pkg::POS_W]] <= 1'b1;
			end
		end
	end

	// item registers and result
	always_ff @(posedge clk) begin
		unique case (state_q)
			iss_pkg::ST_IDLE: begin
				if (accept) begin
					op_q    <= in_op;
					range_q <= in_range;
					w_q     <= W_BITS'(in_key >> iss_pkg::POS_W);
					pos_q   <= in_key[iss_pkg::POS_W-1:0];
				end
			end
			iss_pkg::ST_WORD: begin
				found_q <= 1'b0;
				next_q  <= '0;
				unique case (op_q)
					iss_pkg::OP_TEST: begin
						found_q <= range_q && base_word[pos_q];
					end
					iss_pkg::OP_SEARCH: begin
						priority if (!range_q) begin
							next_q <= NONE_KEY;
						end else if (ffs_hit) begin
							found_q <= 1'b1;
							next_q  <= iss_pkg::NEXT_W'({w_q, ffs_idx});
						end else if (w1[W_BITS]) begin
							next_q <= NONE_KEY;
						end else begin
							w_q   <= w1[W_BITS-1:0];
							i_q   <= wx_next[WX_BITS-1:iss_pkg::POS_W];
							pos_q <= wx_next[iss_pkg::POS_W-1:0];
						end
					end
					default: begin
						found_q <= 1'b0;
					end
				endcase
			end
			iss_pkg::ST_L1: begin
				priority if (ffs_hit) begin
					w_q   <= W_BITS'({i_q, ffs_idx});
					pos_q <= '0;
				end else if (i_end) begin
					found_q <= 1'b0;
					next_q  <= NONE_KEY;
				end else begin
					pos_q <= iss_pkg::POS_W'(i1);
				end
			end
			iss_pkg::ST_L2: begin
				if (ffs_hit) begin
					i_q   <= I_BITS'(ffs_idx);
					pos_q <= '0;
				end else begin
					found_q <= 1'b0;
					next_q  <= NONE_KEY;
				end
			end
			default: begin
				found_q <= found_q;
			end
		endcase
	end

	assign m_tdata = iss_pkg::M_DATA_W'({next_q, found_q});

	`ISS_ASSERT_NOW(a_one_item, s_tready, !m_tvalid, "input ready while a result is pending")
	`ISS_ASSERT_NEXT(a_accept_word, accept, state_q == iss_pkg::ST_WORD,
		"accepted beat did not start a word pass")
	`ISS_ASSERT_NOW(a_write_insert, ram_we, op_q == iss_pkg::OP_INSERT && range_q,
		"bitmap written outside an insert")
	`ISS_ASSERT_NEXT(a_summary_set, ram_we, l1_q[$past(wx_cur)],
		"level-1 bit not set after insert")
	`ISS_ASSERT_NOW(a_insert_zero, m_tvalid && op_q == iss_pkg::OP_INSERT,
		!found_q && next_q == '0, "insert result not zero")

endmodule

`default_nettype wire
